// File: design/soa_pkg.sv
// Shared types, constants and list helpers for the slab object allocator.
`default_nettype none

package soa_pkg;

  localparam int SLOTS     = 16;
  localparam int OBJ_MAX   = 64;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int IDX_W     = $clog2(OBJ_MAX);
  localparam int LINK_W    = IDX_W + 1;
  localparam int LEN_W     = SLOT_W + 1;
  localparam int ADDR_W    = SLOT_W + IDX_W;
  localparam int TOTAL_W   = 11;
  localparam int CNT_CFG_W = 7;

  localparam logic [LINK_W-1:0]  LINK_END  = LINK_W'(OBJ_MAX);
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef enum logic [1:0] {
    K_UNUSED,
    K_EMPTY,
    K_PARTIAL,
    K_FULL
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_NOSLAB,
    ST_REFUSED
  } status_t;

  typedef enum logic {
    OP_ALLOC,
    OP_FREE
  } op_t;

  typedef enum logic {
    REG_OBJS,
    REG_LIMIT
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PICK,
    S_GROW,
    S_GROW_FIN,
    S_TAKE_RD,
    S_TAKE_APPLY,
    S_FCHK,
    S_WALK,
    S_WALK_WAIT,
    S_FREE_APPLY,
    S_REAP,
    S_DONE
  } state_t;

  // One request to the link memory per cycle.
  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [LINK_W-1:0] wdata;
  } link_req_t;

  typedef logic [SLOTS-1:0][SLOT_W-1:0] order_t;

  // Removes the first entry equal to id among the first len entries.
  function automatic order_t ord_remove(order_t a, logic [LEN_W-1:0] len,
                                        logic [SLOT_W-1:0] id);
    order_t r;
    logic   seen;
    r    = a;
    seen = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!seen && (LEN_W'(i) < len) && (a[i] == id)) begin
        seen = 1'b1;
      end
      if (i < SLOTS - 1) begin
        if (seen && (LEN_W'(i + 1) < len)) begin
          r[i] = a[i + 1];
        end
      end
    end
    return r;
  endfunction

  function automatic logic ord_has(order_t a, logic [LEN_W-1:0] len,
                                   logic [SLOT_W-1:0] id);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if ((LEN_W'(i) < len) && (a[i] == id)) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  // Inserts id at the head; a full list is left alone.
  function automatic order_t ord_push(order_t a, logic [LEN_W-1:0] len,
                                      logic [SLOT_W-1:0] id);
    order_t r;
    r = a;
    if (len < LEN_W'(SLOTS)) begin
      for (int j = 1; j < SLOTS; j++) begin
        r[j] = a[j - 1];
      end
      r[0] = id;
    end
    return r;
  endfunction

  function automatic logic [TOTAL_W-1:0] sat_add(logic [TOTAL_W-1:0] t,
                                                 logic [CNT_CFG_W-1:0] v);
    logic [TOTAL_W:0] s;
    s = {1'b0, t} + (TOTAL_W + 1)'(v);
    return s[TOTAL_W] ? TOTAL_MAX : s[TOTAL_W-1:0];
  endfunction

  function automatic logic [TOTAL_W-1:0] sat_sub(logic [TOTAL_W-1:0] t,
                                                 logic [CNT_CFG_W-1:0] v);
    return (t > TOTAL_W'(v)) ? (t - TOTAL_W'(v)) : '0;
  endfunction

endpackage

`default_nettype wire

// File: design/soa_link_ram.sv
// Link memory holding the free-object chains of all slabs.
`default_nettype none

module soa_link_ram (
  input  wire                     clk,
  input  soa_pkg::link_req_t      req,
  output logic [soa_pkg::LINK_W-1:0] rdata_r
);
  import soa_pkg::*;

  logic [LINK_W-1:0] mem [SLOTS*OBJ_MAX];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.addr];
    end
  end

endmodule

`default_nettype wire

// File: design/slab_object_allocator_top.sv
// Top level of the slab object allocator: sequencer, slab tables and lists.
//
//  channel | direction | tuser          | tdata (lowest bit first)
//  in_     | slave     | opcode [0]     | slab_id [3:0], object_index [9:4]
//  out_    | master    | status [1:0]   | granted_slab [3:0], granted_index [9:4],
//          |           |                | free_total [20:10]
//  cfg_    | write     | -              | index 0 objects_per_slab, 1 release threshold
//
// An allocate picks a slab, reads its head and applies; a fresh slab is first
// threaded one link a cycle. A free checks, then walks the slab's chain with a
// read and a wait per entry (single-port link memory) before it applies; when
// slabs are released it frees them from the head of the empty list, then finishes.
// A result then waits in the output register; a new transaction is taken only
// once the previous result has left the sequencer. Reset is synchronous and
// clears slab kinds and list lengths at once; no clearing pass.
`default_nettype none

module slab_object_allocator_top (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [15:0] in_tdata,   // slab_id, object_index
  input  wire  [0:0]  in_tuser,   // opcode
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [23:0] out_tdata,  // granted_slab, granted_index, free_total
  output logic [1:0]  out_tuser,  // status
  input  wire         cfg_we,
  input  wire  [0:0]  cfg_index,
  input  wire  [10:0] cfg_wdata
);
  import soa_pkg::*;

  state_t state_r, state_nxt;

  logic [CNT_CFG_W-1:0] objs_r;
  logic [TOTAL_W-1:0]   limit_r;

  kind_t             kind_r [SLOTS];
  kind_t             kind_nxt [SLOTS];
  logic [LINK_W-1:0] head_r [SLOTS];
  logic [LINK_W-1:0] head_nxt [SLOTS];
  logic [LINK_W-1:0] used_r [SLOTS];
  logic [LINK_W-1:0] used_nxt [SLOTS];
  order_t            part_r, part_nxt, emp_r, emp_nxt;
  logic [LEN_W-1:0]  plen_r, plen_nxt, elen_r, elen_nxt;
  logic [SLOT_W-1:0] cur_r, cur_nxt;
  logic              cur_valid_r, cur_valid_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;

  logic              op_r, op_nxt;
  logic [SLOT_W-1:0] sl_r, sl_nxt;
  logic [IDX_W-1:0]  oi_r, oi_nxt;
  logic [LINK_W-1:0] cnt_r, cnt_nxt;
  logic [LINK_W-1:0] cur_link_r, cur_link_nxt;
  status_t           status_r, status_nxt;
  logic [IDX_W-1:0]  gi_r, gi_nxt;

  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [SLOT_W-1:0] out_gs_r, out_gs_nxt;
  logic [IDX_W-1:0]  out_gi_r, out_gi_nxt;
  logic [TOTAL_W-1:0] out_total_r, out_total_nxt;

  link_req_t         req;
  logic [LINK_W-1:0] rdata;

  logic [CNT_CFG_W-1:0] n_objs;
  logic                 cur_ok;
  logic                 any_unused;
  logic [SLOT_W-1:0]    low_unused;
  logic                 chk_bad;
  logic                 walk_end;
  logic                 walk_hit;
  logic                 out_free;
  logic                 reap_go;
  logic [TOTAL_W-1:0]   free_total_new;
  logic                 free_empties;

  soa_link_ram u_link (
    .clk     (clk),
    .req     (req),
    .rdata_r (rdata)
  );

  assign n_objs = (objs_r < CNT_CFG_W'(2)) ? CNT_CFG_W'(2) :
                  (objs_r > CNT_CFG_W'(OBJ_MAX)) ? CNT_CFG_W'(OBJ_MAX) : objs_r;

  assign cur_ok   = cur_valid_r && (kind_r[cur_r] == K_PARTIAL);
  assign chk_bad  = ({1'b0, oi_r} >= n_objs) || (kind_r[sl_r] == K_UNUSED) ||
                    (used_r[sl_r] == '0);
  assign walk_end = cur_link_r[IDX_W] || cnt_r[IDX_W];
  assign walk_hit = (cur_link_r[IDX_W-1:0] == oi_r);
  assign out_free = !out_valid_r || out_tready;
  assign reap_go  = (elen_r != '0) && (total_r >= limit_r);
  assign free_total_new = sat_add(total_r, CNT_CFG_W'(1));
  assign free_empties   = (used_r[sl_r] == LINK_W'(1));

  always_comb begin
    any_unused = 1'b0;
    low_unused = '0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (kind_r[k] == K_UNUSED) begin
        any_unused = 1'b1;
        low_unused = SLOT_W'(k);
      end
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = (in_tuser[0] == OP_FREE) ? S_FCHK : S_PICK;
        end
      end
      S_PICK: begin
        if (cur_ok || (plen_r != '0) || (elen_r != '0)) begin
          state_nxt = S_TAKE_RD;
        end else if (any_unused) begin
          state_nxt = S_GROW;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_GROW: begin
        if (cnt_r == LINK_W'(n_objs - CNT_CFG_W'(1))) begin
          state_nxt = S_GROW_FIN;
        end
      end
      S_GROW_FIN:   state_nxt = S_TAKE_RD;
      S_TAKE_RD:    state_nxt = S_TAKE_APPLY;
      S_TAKE_APPLY: state_nxt = S_DONE;
      S_FCHK:       state_nxt = chk_bad ? S_DONE : S_WALK;
      S_WALK: begin
        if (walk_end) begin
          state_nxt = S_FREE_APPLY;
        end else if (walk_hit) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_WALK_WAIT;
        end
      end
      S_WALK_WAIT:  state_nxt = S_WALK;
      S_FREE_APPLY: begin
        state_nxt = (free_empties && (free_total_new > limit_r)) ? S_REAP : S_DONE;
      end
      S_REAP: begin
        if (!reap_go) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    kind_nxt      = kind_r;
    head_nxt      = head_r;
    used_nxt      = used_r;
    part_nxt      = part_r;
    emp_nxt       = emp_r;
    plen_nxt      = plen_r;
    elen_nxt      = elen_r;
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    total_nxt     = total_r;
    op_nxt        = op_r;
    sl_nxt        = sl_r;
    oi_nxt        = oi_r;
    cnt_nxt       = cnt_r;
    cur_link_nxt  = cur_link_r;
    status_nxt    = status_r;
    gi_nxt        = gi_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_gs_nxt    = out_gs_r;
    out_gi_nxt    = out_gi_r;
    out_total_nxt = out_total_r;
    req           = '0;
    in_tready     = (state_r == S_IDLE);

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt     = in_tuser[0];
          sl_nxt     = (in_tuser[0] == OP_FREE) ? in_tdata[SLOT_W-1:0] : '0;
          oi_nxt     = in_tdata[SLOT_W +: IDX_W];
          status_nxt = ST_OK;
          gi_nxt     = '0;
        end
      end
      S_PICK: begin
        cnt_nxt = '0;
        if (cur_ok) begin
          sl_nxt = cur_r;
        end else if (plen_r != '0) begin
          sl_nxt = part_r[0];
        end else if (elen_r != '0) begin
          sl_nxt = emp_r[0];
        end else if (any_unused) begin
          sl_nxt = low_unused;
        end else begin
          status_nxt = ST_NOSLAB;
        end
      end
      S_GROW: begin
        req.we    = 1'b1;
        req.addr  = {sl_r, cnt_r[IDX_W-1:0]};
        req.wdata = (cnt_r == LINK_W'(n_objs - CNT_CFG_W'(1))) ? LINK_END : cnt_r + 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
      end
      S_GROW_FIN: begin
        head_nxt[sl_r] = '0;
        used_nxt[sl_r] = '0;
        kind_nxt[sl_r] = K_EMPTY;
        emp_nxt        = ord_push(emp_r, elen_r, sl_r);
        if (elen_r < LEN_W'(SLOTS)) begin
          elen_nxt = elen_r + 1'b1;
        end
        total_nxt = sat_add(total_r, n_objs);
      end
      S_TAKE_RD: begin
        req.re   = 1'b1;
        req.addr = {sl_r, head_r[sl_r][IDX_W-1:0]};
      end
      S_TAKE_APPLY: begin
        // A head past the end reads as end of chain and grants index zero.
        head_nxt[sl_r] = head_r[sl_r][IDX_W] ? LINK_END : rdata;
        gi_nxt         = head_r[sl_r][IDX_W] ? '0 : head_r[sl_r][IDX_W-1:0];
        used_nxt[sl_r] = used_r[sl_r] + 1'b1;
        total_nxt      = sat_sub(total_r, CNT_CFG_W'(1));
        if ((kind_r[sl_r] == K_EMPTY) && ord_has(emp_r, elen_r, sl_r)) begin
          emp_nxt  = ord_remove(emp_r, elen_r, sl_r);
          elen_nxt = elen_r - 1'b1;
        end
        if (head_r[sl_r][IDX_W] || rdata[IDX_W]) begin
          if ((kind_r[sl_r] == K_PARTIAL) && ord_has(part_r, plen_r, sl_r)) begin
            part_nxt = ord_remove(part_r, plen_r, sl_r);
            plen_nxt = plen_r - 1'b1;
          end
          kind_nxt[sl_r] = K_FULL;
          cur_valid_nxt  = 1'b0;
        end else begin
          if (kind_r[sl_r] != K_PARTIAL) begin
            part_nxt = ord_push(part_r, plen_r, sl_r);
            if (plen_r < LEN_W'(SLOTS)) begin
              plen_nxt = plen_r + 1'b1;
            end
            kind_nxt[sl_r] = K_PARTIAL;
          end
          cur_nxt       = sl_r;
          cur_valid_nxt = 1'b1;
        end
      end
      S_FCHK: begin
        cur_link_nxt = head_r[sl_r];
        cnt_nxt      = '0;
        if (chk_bad) begin
          status_nxt = ST_REFUSED;
        end
      end
      S_WALK: begin
        if (!walk_end) begin
          if (walk_hit) begin
            status_nxt = ST_REFUSED;
          end else begin
            req.re   = 1'b1;
            req.addr = {sl_r, cur_link_r[IDX_W-1:0]};
          end
        end
      end
      S_WALK_WAIT: begin
        cur_link_nxt = rdata;
        cnt_nxt      = cnt_r + 1'b1;
      end
      S_FREE_APPLY: begin
        req.we         = 1'b1;
        req.addr       = {sl_r, oi_r};
        req.wdata      = head_r[sl_r];
        head_nxt[sl_r] = {1'b0, oi_r};
        used_nxt[sl_r] = used_r[sl_r] - 1'b1;
        total_nxt      = free_total_new;
        if (free_empties) begin
          if ((kind_r[sl_r] == K_PARTIAL) && ord_has(part_r, plen_r, sl_r)) begin
            part_nxt = ord_remove(part_r, plen_r, sl_r);
            plen_nxt = plen_r - 1'b1;
          end
          kind_nxt[sl_r] = K_EMPTY;
          emp_nxt        = ord_push(emp_r, elen_r, sl_r);
          if (elen_r < LEN_W'(SLOTS)) begin
            elen_nxt = elen_r + 1'b1;
          end
          if (cur_valid_r && (cur_r == sl_r)) begin
            cur_valid_nxt = 1'b0;
          end
        end
      end
      S_REAP: begin
        // Release the slab at the head of the empty list, one per cycle.
        if (reap_go) begin
          emp_nxt          = ord_remove(emp_r, elen_r, emp_r[0]);
          elen_nxt         = elen_r - 1'b1;
          kind_nxt[emp_r[0]] = K_UNUSED;
          total_nxt        = sat_sub(total_r, n_objs);
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_gs_nxt     = ((op_r == OP_ALLOC) && (status_r == ST_OK)) ? sl_r : '0;
          out_gi_nxt     = gi_r;
          out_total_nxt  = total_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      objs_r      <= CNT_CFG_W'(OBJ_MAX);
      limit_r     <= '0;
      plen_r      <= '0;
      elen_r      <= '0;
      cur_r       <= '0;
      cur_valid_r <= 1'b0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < SLOTS; k++) begin
        kind_r[k] <= K_UNUSED;
      end
    end else begin
      state_r     <= state_nxt;
      plen_r      <= plen_nxt;
      elen_r      <= elen_nxt;
      cur_r       <= cur_nxt;
      cur_valid_r <= cur_valid_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      kind_r      <= kind_nxt;
      if (cfg_we) begin
        if (cfg_index[0] == REG_OBJS) begin
          objs_r <= cfg_wdata[CNT_CFG_W-1:0];
        end else begin
          limit_r <= cfg_wdata;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    head_r       <= head_nxt;
    used_r       <= used_nxt;
    part_r       <= part_nxt;
    emp_r        <= emp_nxt;
    op_r         <= op_nxt;
    sl_r         <= sl_nxt;
    oi_r         <= oi_nxt;
    cnt_r        <= cnt_nxt;
    cur_link_r   <= cur_link_nxt;
    status_r     <= status_nxt;
    gi_r         <= gi_nxt;
    out_status_r <= out_status_nxt;
    out_gs_r     <= out_gs_nxt;
    out_gi_r     <= out_gi_nxt;
    out_total_r  <= out_total_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {3'b000, out_total_r, out_gi_r, out_gs_r};

endmodule

`default_nettype wire

// File: design/soa_checker.sv
// Port-level checks for the slab object allocator, bound to its top level.
`default_nettype none

module soa_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tvalid,
  input wire        in_tready,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [23:0] out_tdata,
  input wire [1:0]  out_tuser
);
  import soa_pkg::*;

  // A result is held until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // The sequencer works on one transaction at a time.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("accepted a transaction while busy");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ST_OK || out_tuser == ST_NOSLAB ||
                    out_tuser == ST_REFUSED))
    else $error("status code out of range");

  // Failed transactions grant nothing.
  a_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_OK) |-> (out_tdata[9:0] == 10'd0))
    else $error("grant reported on failed transaction");

endmodule

bind slab_object_allocator_top soa_checker u_soa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

// File: tb/slab_object_allocator_top_test.sv
// Self-checking testbench for the slab object allocator: directed and random traffic against a predictor.
`default_nettype none

module slab_object_allocator_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import soa_pkg::*;

  typedef struct packed {
    op_t        op;
    logic [3:0] sid;
    logic [5:0] oi;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [3:0]  slab;
    logic [5:0]  idx;
    logic [10:0] total;
  } grant_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [10:0] cfg_wdata = '0;

  slab_object_allocator_top dut (.*);

  // Predictor copy of the allocator state.
  logic [6:0]  chain_link [SLOTS][OBJ_MAX];
  logic [6:0]  chain_head [SLOTS];
  logic [6:0]  in_use [SLOTS];
  kind_t       slab_state [SLOTS];
  logic [3:0]  partial_q [$];
  logic [3:0]  empty_q [$];
  logic [3:0]  cur_slab;
  logic        cur_live;
  logic [10:0] spare_total;
  logic [6:0]  objs_reg;
  logic [10:0] limit_reg;

  req_t        pending_reqs [$];
  grant_t      expected_grants [$];
  logic [9:0]  held_handles [$];
  int          errors = 0;
  logic        in_fire = 1'b0;
  logic        quiet = 1'b0;
  int          in_gap = 0;
  int          out_gap = 0;

  initial forever #5 clk = ~clk;

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

  function automatic int eff_objs();
    if (objs_reg < 2) return 2;
    if (objs_reg > OBJ_MAX) return OBJ_MAX;
    return objs_reg;
  endfunction

  function automatic void drop_id(ref logic [3:0] q [$], input logic [3:0] id);
    for (int i = 0; i < q.size(); i++) begin
      if (q[i] == id) begin
        q.delete(i);
        return;
      end
    end
  endfunction

  function automatic void add_spare(int v);
    int t;
    t = spare_total + v;
    spare_total = (t > 2047) ? 11'd2047 : t[10:0];
  endfunction

  function automatic void take_spare(int v);
    spare_total = (spare_total > v) ? 11'(spare_total - v) : '0;
  endfunction

  function automatic grant_t allocate_or_free(req_t r);
    grant_t g;
    int n, s, k, idx, nxt, c;
    logic bad;
    g = '{status: ST_OK, slab: '0, idx: '0, total: '0};
    n = eff_objs();
    if (r.op == OP_ALLOC) begin
      s = SLOTS;
      if (cur_live && slab_state[cur_slab] == K_PARTIAL) s = cur_slab;
      else if (partial_q.size() > 0) s = partial_q[0];
      else if (empty_q.size() > 0) s = empty_q[0];
      else begin
        for (k = 0; k < SLOTS; k++) if (slab_state[k] == K_UNUSED) break;
        if (k < SLOTS) begin
          for (int i = 0; i + 1 < n; i++) chain_link[k][i] = 7'(i + 1);
          chain_link[k][n-1] = 7'(OBJ_MAX);
          chain_head[k] = '0;
          in_use[k] = '0;
          slab_state[k] = K_EMPTY;
          empty_q.push_front(k[3:0]);
          add_spare(n);
          s = k;
        end
      end
      if (s >= SLOTS) g.status = ST_NOSLAB;
      else begin
        idx = chain_head[s];
        nxt = (idx < OBJ_MAX) ? chain_link[s][idx] : OBJ_MAX;
        if (idx >= OBJ_MAX) idx = 0;
        chain_head[s] = nxt[6:0];
        in_use[s] = in_use[s] + 7'd1;
        take_spare(1);
        if (slab_state[s] == K_EMPTY) drop_id(empty_q, s[3:0]);
        if (nxt >= OBJ_MAX) begin
          if (slab_state[s] == K_PARTIAL) drop_id(partial_q, s[3:0]);
          slab_state[s] = K_FULL;
          cur_live = 1'b0;
        end else begin
          if (slab_state[s] != K_PARTIAL) begin
            partial_q.push_front(s[3:0]);
            slab_state[s] = K_PARTIAL;
          end
          cur_slab = s[3:0];
          cur_live = 1'b1;
        end
        g.slab = s[3:0];
        g.idx = idx[5:0];
      end
    end else begin
      bad = (r.oi >= n) || slab_state[r.sid] == K_UNUSED || in_use[r.sid] == 0;
      if (!bad) begin
        c = chain_head[r.sid];
        for (int st = 0; st < OBJ_MAX && c < OBJ_MAX; st++) begin
          if (c == r.oi) begin
            bad = 1'b1;
            break;
          end
          c = chain_link[r.sid][c];
        end
      end
      if (bad) g.status = ST_REFUSED;
      else begin
        chain_link[r.sid][r.oi] = chain_head[r.sid];
        chain_head[r.sid] = {1'b0, r.oi};
        in_use[r.sid] = in_use[r.sid] - 7'd1;
        add_spare(1);
        if (in_use[r.sid] == 0) begin
          if (slab_state[r.sid] == K_PARTIAL) drop_id(partial_q, r.sid);
          slab_state[r.sid] = K_EMPTY;
          empty_q.push_front(r.sid);
          if (cur_live && cur_slab == r.sid) cur_live = 1'b0;
          if (spare_total > limit_reg) begin
            // Release empty slabs from the head while the total holds up.
            while (empty_q.size() > 0 && spare_total >= limit_reg) begin
              slab_state[empty_q[0]] = K_UNUSED;
              void'(empty_q.pop_front());
              take_spare(n);
            end
          end
        end
      end
    end
    g.total = spare_total;
    return g;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Monitor and predictor: everything sampled at the rising edge.
  always @(posedge clk) begin
    grant_t e, g;
    in_fire <= rst_n && in_tvalid && in_tready;
    if (rst_n && out_tvalid && out_tready) begin
      g = '{status: status_t'(out_tuser), slab: out_tdata[3:0], idx: out_tdata[9:4],
            total: out_tdata[20:10]};
      if (expected_grants.size() == 0) report("unexpected transaction", 1, 0);
      else begin
        e = expected_grants.pop_front();
        if (g.status != e.status) report("status", g.status, e.status);
        if (g.slab != e.slab) report("granted_slab", g.slab, e.slab);
        if (g.idx != e.idx) report("granted_index", g.idx, e.idx);
        if (g.total != e.total) report("free_total", g.total, e.total);
      end
    end
    if (rst_n && in_tvalid && in_tready) begin
      e = allocate_or_free('{op: op_t'(in_tuser[0]), sid: in_tdata[3:0], oi: in_tdata[9:4]});
      expected_grants.push_back(e);
      if (e.status == ST_OK) begin
        if (in_tuser[0] == OP_ALLOC) held_handles.push_back({e.idx, e.slab});
        else begin
          for (int i = 0; i < held_handles.size(); i++) begin
            if (held_handles[i] == in_tdata[9:0]) begin
              held_handles.delete(i);
              break;
            end
          end
        end
      end
    end
  end

  // Driver: inputs change at the falling edge only.
  always @(negedge clk) begin
    req_t r;
    if (!in_tvalid || in_fire) begin
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        in_gap = $urandom_range(0, 9);
        in_tvalid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        r = pending_reqs.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= r.op;
        in_tdata <= {6'd0, r.oi, r.sid};
      end else in_tvalid <= 1'b0;
    end
    if (out_gap > 0) begin
      out_gap--;
      out_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      out_gap = $urandom_range(0, 9);
      out_tready <= 1'b0;
    end else out_tready <= 1'b1;
  end

  task automatic push_req(op_t op, int sid, int oi);
    pending_reqs.push_back('{op: op, sid: sid[3:0], oi: oi[5:0]});
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_reqs.size() > 0 || in_tvalid || expected_grants.size() > 0);
    repeat (5) @(posedge clk);
  endtask

  task automatic set_regs(int objs, int lim);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_OBJS;
    cfg_wdata <= 11'(objs);
    objs_reg = objs[6:0];
    @(negedge clk);
    cfg_index <= REG_LIMIT;
    cfg_wdata <= 11'(lim);
    limit_reg = lim[10:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random allocates and frees; most frees are of held objects, with some stray and double frees mixed in.
  task automatic random_phase(int count, int alloc_pct);
    int h;
    for (int k = 0; k < count; k++) begin
      while (pending_reqs.size() > 0) @(posedge clk);
      if ($urandom_range(0, 99) < alloc_pct)
        push_req(OP_ALLOC, $urandom_range(0, 15), $urandom_range(0, 63));
      else if (held_handles.size() > 0 && $urandom_range(0, 9) != 0) begin
        h = held_handles[$urandom_range(0, held_handles.size() - 1)];
        push_req(OP_FREE, h[3:0], h[9:4]);
      end else push_req(OP_FREE, $urandom_range(0, 15), $urandom_range(0, 63));
    end
    wait_idle();
  endtask

  initial begin
    for (int s = 0; s < SLOTS; s++) begin
      slab_state[s] = K_UNUSED;
      chain_head[s] = '0;
      in_use[s] = '0;
      for (int i = 0; i < OBJ_MAX; i++) chain_link[s][i] = '0;
    end
    cur_slab = '0;
    cur_live = 1'b0;
    spare_total = '0;
    objs_reg = 7'd64;
    limit_reg = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: grow, double free, stray frees, empty-and-release.
    push_req(OP_ALLOC, 15, 63);
    push_req(OP_ALLOC, 0, 0);
    push_req(OP_ALLOC, 0, 0);
    push_req(OP_FREE, 0, 1);
    push_req(OP_FREE, 0, 1);
    push_req(OP_FREE, 15, 0);
    push_req(OP_FREE, 0, 63);
    push_req(OP_FREE, 0, 0);
    push_req(OP_FREE, 0, 2);
    push_req(OP_FREE, 0, 0);
    push_req(OP_ALLOC, 0, 0);
    wait_idle();
    set_regs(0, 0);
    for (int i = 0; i < 34; i++) push_req(OP_ALLOC, 0, 0);
    push_req(OP_FREE, 3, 1);
    push_req(OP_FREE, 3, 2);
    push_req(OP_FREE, 3, 1);
    wait_idle();

    set_regs(4, 8);
    random_phase(70, 60);
    set_regs(127, 2047);
    random_phase(60, 55);
    set_regs(2, 1024);
    random_phase(70, 55);
    set_regs(8, 3);
    random_phase(70, 50);
    set_regs(64, 0);
    random_phase(50, 50);
    set_regs(3, 5);
    quiet = 1'b1;
    random_phase(60, 55);

    repeat (20) @(posedge clk);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
design/soa_pkg.sv
design/soa_link_ram.sv
design/slab_object_allocator_top.sv
design/soa_checker.sv
tb/slab_object_allocator_top_test.sv
